// ===== src/beep_envelope_sequencer_top_macros.svh =====
// assertion helpers shared by the sequencer modules
`ifndef BEEP_ENVELOPE_SEQUENCER_TOP_MACROS_SVH
`define BEEP_ENVELOPE_SEQUENCER_TOP_MACROS_SVH

// condition holds on every clock edge out of reset
`define BES_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define BES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bes_pkg.sv =====
package bes_pkg;

    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 8;
    localparam int TIME_W     = 16;
    localparam int FADE_W     = 10;
    localparam int DUTY_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam int FADE_STEPS_DEF = 10;

    localparam logic [DUTY_W-1:0] PEAK_MAX   = 7'd100;
    localparam logic [FADE_W-1:0] FADE_RESET = 10'd30;
    localparam logic [DUTY_W-1:0] PEAK_RESET = 7'd50;

    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEEP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_TIME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_DUTY = 1'd1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] beep_count;
        logic [TIME_W-1:0]  on_time_ms;
        logic [TIME_W-1:0]  off_time_ms;
    } t_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              busy_res;
        logic              done_res;
        logic              rejected;
    } t_result;

endpackage

// ===== src/bes_div_const.sv =====
module bes_div_const #(
    parameter int IN_W    = 10,
    parameter int DIVISOR = 10
) (
    input  logic [IN_W-1:0] i_num,
    output logic [IN_W-1:0] o_quot
);

    localparam int SHIFT  = IN_W + $clog2(DIVISOR);
    localparam int PROD_W = IN_W + SHIFT + 1;
    localparam logic [SHIFT:0] RECIP = (SHIFT+1)'((2**SHIFT + DIVISOR - 1) / DIVISOR);

    logic [PROD_W-1:0] prod;

    // multiply by the rounded-up reciprocal, exact over the whole input range
    assign prod   = PROD_W'(i_num) * PROD_W'(RECIP);
    assign o_quot = prod[SHIFT +: IN_W];

endmodule

// ===== src/bes_envelope_core.sv =====
`include "beep_envelope_sequencer_top_macros.svh"

module bes_envelope_core #(
    parameter int FADE_STEPS = bes_pkg::FADE_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  bes_pkg::t_item              i_item,
    input  logic [bes_pkg::FADE_W-1:0]  i_fade_time_ms,
    input  logic [bes_pkg::DUTY_W-1:0]  i_peak_duty,
    output bes_pkg::t_result            o_result
);

    localparam int STEP_W = $clog2(FADE_STEPS + 1);
    localparam int ACC_W  = bes_pkg::DUTY_W + STEP_W;
    localparam int FW     = bes_pkg::FADE_W;
    localparam int TW     = bes_pkg::TIME_W;
    localparam int DW     = bes_pkg::DUTY_W;
    localparam logic [STEP_W-1:0] RAMP_LAST = STEP_W'(FADE_STEPS);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_UP,
        PH_HOLD,
        PH_DOWN,
        PH_GAP,
        PH_START_UP,
        PH_STOP_DOWN
    } t_phase;

    t_phase                         r_phase, c_phase, n_phase;
    logic [STEP_W-1:0]              r_ramp, c_ramp, n_ramp;
    logic [TW-1:0]                  r_ms, c_ms, n_ms;
    logic [FW-1:0]                  r_step_len, c_step_len, n_step_len;
    logic [TW-1:0]                  r_hold, c_hold, n_hold;
    logic [bes_pkg::COUNT_W-1:0]    r_beeps, c_beeps, n_beeps;
    logic [TW-1:0]                  r_gap, c_gap, n_gap;
    logic [DW-1:0]                  r_duty, n_duty;

    logic [DW-1:0]    peak;
    logic             short_beep;
    logic [FW-1:0]    fade_sel;
    logic [FW-1:0]    step_quot;
    logic [FW-1:0]    step_new;
    logic [TW-1:0]    hold_new;
    logic [ACC_W-1:0] part_prod;
    logic [ACC_W-1:0] part_quot;
    logic [DW-1:0]    part;
    logic [DW-1:0]    level;
    logic [TW-1:0]    ms_dec;
    logic             rej;
    logic             instant_done;
    logic             done;

    assign peak = (i_peak_duty > bes_pkg::PEAK_MAX) ? bes_pkg::PEAK_MAX : i_peak_duty;

    // fade shrinks to half the beep when the beep is too short for two ramps
    assign short_beep = {1'b0, i_item.on_time_ms} <= {(TW - FW)'(0), i_fade_time_ms, 1'b0};
    assign fade_sel   = (i_item.mode == bes_pkg::MODE_BEEP && short_beep)
                        ? i_item.on_time_ms[FW:1] : i_fade_time_ms;
    assign hold_new   = i_item.on_time_ms - {(TW - FW - 1)'(0), fade_sel, 1'b0};

    bes_div_const #(
        .IN_W    (FW),
        .DIVISOR (FADE_STEPS)
    ) u_step_div (
        .i_num  (fade_sel),
        .o_quot (step_quot)
    );

    assign step_new = (step_quot == '0) ? FW'(1) : step_quot;

    always_comb begin
        c_phase      = r_phase;
        c_ramp       = r_ramp;
        c_ms         = r_ms;
        c_step_len   = r_step_len;
        c_hold       = r_hold;
        c_beeps      = r_beeps;
        c_gap        = r_gap;
        rej          = 1'b0;
        instant_done = 1'b0;
        if (i_item.mode != bes_pkg::MODE_TICK) begin
            if (r_phase != PH_IDLE) begin
                rej = 1'b1;
            end else if (i_item.mode == bes_pkg::MODE_BEEP) begin
                if (i_item.beep_count == '0) begin
                    instant_done = 1'b1;
                end else begin
                    c_step_len = step_new;
                    c_hold     = hold_new;
                    c_beeps    = i_item.beep_count - 1'b1;
                    c_gap      = i_item.off_time_ms;
                    c_phase    = PH_UP;
                    c_ramp     = '0;
                    c_ms       = TW'(step_new);
                end
            end else begin
                c_step_len = step_new;
                c_phase    = (i_item.mode == bes_pkg::MODE_START) ? PH_START_UP : PH_STOP_DOWN;
                c_ramp     = '0;
                c_ms       = TW'(step_new);
            end
        end
    end

    // ramp level is the live peak times the ramp step over the step count
    assign part_prod = ACC_W'(peak) * ACC_W'(c_ramp);

    bes_div_const #(
        .IN_W    (ACC_W),
        .DIVISOR (FADE_STEPS)
    ) u_part_div (
        .i_num  (part_prod),
        .o_quot (part_quot)
    );

    assign part = part_quot[DW-1:0];

    always_comb begin
        case (c_phase)
            PH_UP, PH_START_UP:   level = part;
            PH_HOLD:              level = peak;
            PH_DOWN, PH_STOP_DOWN: level = (part > peak) ? '0 : peak - part;
            PH_GAP:               level = '0;
            default:              level = r_duty;
        endcase
    end

    assign ms_dec = (c_ms != '0) ? c_ms - 1'b1 : '0;

    always_comb begin
        n_phase    = c_phase;
        n_ramp     = c_ramp;
        n_ms       = c_ms;
        n_step_len = c_step_len;
        n_hold     = c_hold;
        n_beeps    = c_beeps;
        n_gap      = c_gap;
        n_duty     = r_duty;
        done       = instant_done;
        if (!instant_done && c_phase != PH_IDLE) begin
            n_duty = level;
            n_ms   = ms_dec;
            if (ms_dec == '0) begin
                case (c_phase)
                    PH_UP, PH_START_UP: begin
                        if (c_ramp < RAMP_LAST) begin
                            n_ramp = c_ramp + 1'b1;
                            n_ms   = TW'(c_step_len);
                        end else if (c_phase == PH_START_UP) begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end else if (c_hold != '0) begin
                            n_phase = PH_HOLD;
                            n_ms    = c_hold;
                        end else begin
                            n_phase = PH_DOWN;
                            n_ramp  = '0;
                            n_ms    = TW'(c_step_len);
                        end
                    end
                    PH_HOLD: begin
                        n_phase = PH_DOWN;
                        n_ramp  = '0;
                        n_ms    = TW'(c_step_len);
                    end
                    PH_DOWN, PH_STOP_DOWN: begin
                        if (c_ramp < RAMP_LAST) begin
                            n_ramp = c_ramp + 1'b1;
                            n_ms   = TW'(c_step_len);
                        end else if (c_phase == PH_DOWN && c_beeps != '0) begin
                            n_beeps = c_beeps - 1'b1;
                            if (c_gap != '0) begin
                                n_phase = PH_GAP;
                                n_ms    = c_gap;
                            end else begin
                                n_phase = PH_UP;
                                n_ramp  = '0;
                                n_ms    = TW'(c_step_len);
                            end
                        end else begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end
                    end
                    PH_GAP: begin
                        n_phase = PH_UP;
                        n_ramp  = '0;
                        n_ms    = TW'(c_step_len);
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_ramp     <= '0;
            r_ms       <= '0;
            r_step_len <= FW'(1);
            r_hold     <= '0;
            r_beeps    <= '0;
            r_gap      <= '0;
            r_duty     <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_ramp     <= n_ramp;
            r_ms       <= n_ms;
            r_step_len <= n_step_len;
            r_hold     <= n_hold;
            r_beeps    <= n_beeps;
            r_gap      <= n_gap;
            r_duty     <= n_duty;
        end
    end

    assign o_result.duty     = n_duty;
    assign o_result.busy_res = (n_phase != PH_IDLE);
    assign o_result.done_res = done;
    assign o_result.rejected = rej;

    `BES_ASSERT_ALWAYS(a_ramp_in_range, i_clk, i_rst_n, r_ramp <= RAMP_LAST, "ramp past last")
    `BES_ASSERT_IMP(a_ms_live, i_clk, i_rst_n, r_phase != PH_IDLE, r_ms != '0, "no time left")

endmodule

// ===== src/beep_envelope_sequencer_top.sv =====
// Buzzer duty envelope sequencer.
// Each input item is one millisecond: mode 0 is a plain tick, mode 1 starts a
// run of beeps, mode 2 ramps up and holds, mode 3 ramps down from peak.
// A command that arrives while a sequence runs is dropped and flagged.
// Each item yields exactly one result item: the duty for that millisecond,
// busy, done and rejected flags.
// Input and output channels are valid/ready. An accepted item sits in an
// input register; an edge on which the result register is free or drains
// computes the envelope step in one pass and loads the result register.
// Throughput is one item per cycle unless the receiver stalls.
// When the receiver stalls, the result register holds and the input register
// still takes one more item, after which ready drops until the result moves.
// The config port writes fade_time_ms (index 0) and peak_duty (index 1) on
// any edge with the write enable high; write only while no item is in flight.
// Synchronous reset empties both registers, returns the sequence to idle
// with duty 0, and restores fade 30 ms and peak 50 percent.
`include "beep_envelope_sequencer_top_macros.svh"

module beep_envelope_sequencer_top #(
    parameter int FADE_STEPS = bes_pkg::FADE_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [bes_pkg::MODE_W-1:0]      i_mode,
    input  logic [bes_pkg::COUNT_W-1:0]     i_beep_count,
    input  logic [bes_pkg::TIME_W-1:0]      i_on_time_ms,
    input  logic [bes_pkg::TIME_W-1:0]      i_off_time_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [bes_pkg::DUTY_W-1:0]      o_duty,
    output logic                            o_busy_res,
    output logic                            o_done_res,
    output logic                            o_rejected,
    input  logic                            i_cfg_wr_en,
    input  logic [bes_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bes_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic                           r_in_valid;
    bes_pkg::t_item                 r_item;
    logic                           r_out_valid;
    bes_pkg::t_result               r_result;
    logic [bes_pkg::FADE_W-1:0]     r_fade_time_ms;
    logic [bes_pkg::DUTY_W-1:0]     r_peak_duty;

    logic             advance;
    logic             in_take;
    bes_pkg::t_result step_result;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.mode        <= i_mode;
            r_item.beep_count  <= i_beep_count;
            r_item.on_time_ms  <= i_on_time_ms;
            r_item.off_time_ms <= i_off_time_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_time_ms <= bes_pkg::FADE_RESET;
            r_peak_duty    <= bes_pkg::PEAK_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bes_pkg::CFG_FADE_TIME: r_fade_time_ms <= i_cfg_wdata;
                bes_pkg::CFG_PEAK_DUTY: r_peak_duty    <= i_cfg_wdata[bes_pkg::DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bes_envelope_core #(
        .FADE_STEPS (FADE_STEPS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_item         (r_item),
        .i_fade_time_ms (r_fade_time_ms),
        .i_peak_duty    (r_peak_duty),
        .o_result       (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_duty      = r_result.duty;
    assign o_busy_res  = r_result.busy_res;
    assign o_done_res  = r_result.done_res;
    assign o_rejected  = r_result.rejected;

    `BES_ASSERT_IMP(a_duty_max, i_clk, i_rst_n, o_out_valid, o_duty <= bes_pkg::PEAK_MAX, "bad duty")
    `BES_ASSERT_IMP(a_done, i_clk, i_rst_n, o_out_valid && o_done_res, !o_busy_res, "busy at done")
    `BES_ASSERT_NEXT(a_moves, i_clk, i_rst_n, r_in_valid && !r_out_valid, r_out_valid, "stuck")

endmodule
